// File: rtl/ring_buffer_deque_top_macros.svh
// Assertion macros for ring_buffer_deque_top.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef RING_BUFFER_DEQUE_TOP_MACROS_SVH
`define RING_BUFFER_DEQUE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBDQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbdq: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RBDQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbdq: next-cycle check failed");

`endif

// File: rtl/rbdq_pkg.sv
// Shared types and constants for the ring buffer deque.
// Used by rbdq_ctrl, rbdq_out and ring_buffer_deque_top.
`timescale 1ns / 1ps

package rbdq_pkg;

	localparam int CMD_W   = 3;
	localparam int VAL_W   = 32;
	localparam int OFF_W   = 4;
	localparam int ST_W    = 2;
	localparam int CNT_W   = 5;
	localparam int SEL_W   = 2;

	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;

	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

	// Source of the front or back value after a request.
	localparam logic [SEL_W-1:0] SEL_KEEP  = 2'd0;
	localparam logic [SEL_W-1:0] SEL_VALUE = 2'd1;
	localparam logic [SEL_W-1:0] SEL_MEM   = 2'd2;
	localparam logic [SEL_W-1:0] SEL_ZERO  = 2'd3;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [SEL_W-1:0] front_sel;
		logic [SEL_W-1:0] back_sel;
		logic             rd_hit;
		logic [CNT_W-1:0] count;
		logic             empty;
	} req_info_t;

endpackage

// File: rtl/rbdq_mem.sv
// Element storage: one write port, one read port with registered data.
// No package dependency.
`timescale 1ns / 1ps

module rbdq_mem #(
	parameter int DEPTH = 16,
	parameter int DW    = 32,
	localparam int PW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [PW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [PW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/rbdq_ctrl.sv
// Pointer and count state, request decode and the first pipeline register.
// Depends on rbdq_pkg; drives the ports of rbdq_mem.
`timescale 1ns / 1ps

module rbdq_ctrl import rbdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int DW    = DATA_W_DEF,
	localparam int PW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [CMD_W-1:0] cmd,
	input  logic [DW-1:0]    value,
	input  logic [OFF_W-1:0] offset,
	output logic             wr_en,
	output logic [PW-1:0]    wr_addr,
	output logic [DW-1:0]    wr_data,
	output logic             rd_en,
	output logic [PW-1:0]    rd_addr,
	output req_info_t        info_s1,
	output logic [DW-1:0]    value_s1
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > OFF_W) ? CW : OFF_W;
	localparam int SW   = ((PW > OFF_W) ? PW : OFF_W) + 1;

	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] fill_q;

	logic [PW-1:0] head_nx, tail_nx;
	logic [CW-1:0] fill_nx;
	logic [PW-1:0] head_inc, head_dec, tail_inc, tail_dec, tail_dec2;
	logic [SW-1:0] off_sum;
	logic [PW-1:0] off_addr;
	logic          full, empty, single;
	req_info_t     info;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p);
		return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
	endfunction

	assign head_inc  = wrap_inc(head_q);
	assign head_dec  = wrap_dec(head_q);
	assign tail_inc  = wrap_inc(tail_q);
	assign tail_dec  = wrap_dec(tail_q);
	assign tail_dec2 = wrap_dec(tail_dec);

	assign full   = (fill_q == CW'(DEPTH));
	assign empty  = (fill_q == '0);
	assign single = (fill_q == CW'(1));

	assign off_sum  = SW'(head_q) + SW'(offset);
	assign off_addr = (off_sum >= SW'(DEPTH)) ? PW'(off_sum - SW'(DEPTH)) : PW'(off_sum);

	assign wr_data = value;

	always_comb begin
		head_nx        = head_q;
		tail_nx        = tail_q;
		fill_nx        = fill_q;
		wr_en          = 1'b0;
		wr_addr        = tail_q;
		rd_en          = 1'b0;
		rd_addr        = head_inc;
		info.status    = ST_OK;
		info.front_sel = SEL_KEEP;
		info.back_sel  = SEL_KEEP;
		info.rd_hit    = 1'b0;
		unique case (cmd)
			CMD_PUSH_BACK: begin
				if (full) begin
					info.status = ST_FULL;
				end else begin
					wr_en          = accept;
					wr_addr        = tail_q;
					tail_nx        = tail_inc;
					fill_nx        = fill_q + 1'b1;
					info.back_sel  = SEL_VALUE;
					info.front_sel = empty ? SEL_VALUE : SEL_KEEP;
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					info.status = ST_FULL;
				end else begin
					wr_en          = accept;
					wr_addr        = head_dec;
					head_nx        = head_dec;
					fill_nx        = fill_q + 1'b1;
					info.front_sel = SEL_VALUE;
					info.back_sel  = empty ? SEL_VALUE : SEL_KEEP;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					info.status = ST_UNDERFLOW;
				end else begin
					tail_nx = tail_dec;
					fill_nx = fill_q - 1'b1;
					if (!single) begin
						rd_en         = accept;
						rd_addr       = tail_dec2;
						info.back_sel = SEL_MEM;
					end
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					info.status = ST_UNDERFLOW;
				end else begin
					head_nx = head_inc;
					fill_nx = fill_q - 1'b1;
					if (!single) begin
						rd_en          = accept;
						rd_addr        = head_inc;
						info.front_sel = SEL_MEM;
					end
				end
			end
			CMD_READ: begin
				if (CMPW'(offset) >= CMPW'(fill_q)) begin
					info.status = ST_RANGE;
				end else begin
					rd_en       = accept;
					rd_addr     = off_addr;
					info.rd_hit = 1'b1;
				end
			end
			CMD_CLEAR: begin
				head_nx = '0;
				tail_nx = '0;
				fill_nx = '0;
			end
			default: begin
			end
		endcase
		// empty after the request: report zero at both ends
		if (fill_nx == '0) begin
			info.front_sel = SEL_ZERO;
			info.back_sel  = SEL_ZERO;
		end
		info.count = CNT_W'(fill_nx);
		info.empty = (fill_nx == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			head_q <= head_nx;
			tail_q <= tail_nx;
			fill_q <= fill_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1  <= info;
			value_s1 <= value;
		end
	end

endmodule

// File: rtl/rbdq_out.sv
// Result stage: resolves front/back/read values and holds the result register.
// Depends on rbdq_pkg; takes stage-one data from rbdq_ctrl and rbdq_mem.
`timescale 1ns / 1ps

module rbdq_out import rbdq_pkg::*; #(
	parameter int DW = DATA_W_DEF
) (
	input  logic                    clk,
	input  logic                    load,
	input  req_info_t               info_s1,
	input  logic [DW-1:0]           value_s1,
	input  logic [DW-1:0]           mem_data,
	output logic [ST_W-1:0]         status,
	output logic signed [VAL_W-1:0] read_data,
	output logic signed [VAL_W-1:0] front_data,
	output logic signed [VAL_W-1:0] back_data,
	output logic [CNT_W-1:0]        count,
	output logic                    is_empty
);

	logic [DW-1:0]    front_q, back_q;
	logic [DW-1:0]    front_res, back_res, rd_res;
	logic [ST_W-1:0]  status_q;
	logic [DW-1:0]    rd_q;
	logic [CNT_W-1:0] count_q;
	logic             empty_q;

	function automatic logic [DW-1:0] pick(input logic [SEL_W-1:0] sel,
		input logic [DW-1:0] kept, input logic [DW-1:0] val, input logic [DW-1:0] mem);
		logic [DW-1:0] r;
		unique case (sel)
			SEL_KEEP:  r = kept;
			SEL_VALUE: r = val;
			SEL_MEM:   r = mem;
			default:   r = '0;
		endcase
		return r;
	endfunction

	assign front_res = pick(info_s1.front_sel, front_q, value_s1, mem_data);
	assign back_res  = pick(info_s1.back_sel, back_q, value_s1, mem_data);
	assign rd_res    = info_s1.rd_hit ? mem_data : '0;

	always_ff @(posedge clk) begin
		if (load) begin
			front_q  <= front_res;
			back_q   <= back_res;
			rd_q     <= rd_res;
			status_q <= info_s1.status;
			count_q  <= info_s1.count;
			empty_q  <= info_s1.empty;
		end
	end

	assign status     = status_q;
	assign read_data  = VAL_W'(rd_q);
	assign front_data = VAL_W'(front_q);
	assign back_data  = VAL_W'(back_q);
	assign count      = count_q;
	assign is_empty   = empty_q;

endmodule

// File: rtl/ring_buffer_deque_top.sv
// Ring buffer deque: takes one request per cycle. A request accepted at one clock
// edge is held in the request register, with its element read landing at the same
// edge; the result register loads from it once the output can advance, then res_valid
// rises. Full throughput holds as long as the result side does not stall.
`timescale 1ns / 1ps

module ring_buffer_deque_top import rbdq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_W_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_stall,
	input  logic [CMD_W-1:0]        cmd,
	input  logic signed [VAL_W-1:0] value,
	input  logic [OFF_W-1:0]        offset,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [ST_W-1:0]         status,
	output logic signed [VAL_W-1:0] read_data,
	output logic signed [VAL_W-1:0] front_data,
	output logic signed [VAL_W-1:0] back_data,
	output logic [CNT_W-1:0]        count,
	output logic                    is_empty
);

`include "ring_buffer_deque_top_macros.svh"

	localparam int PW = $clog2(DEPTH);

	logic                  s1_valid_q, out_valid_q;
	logic                  out_adv, accept, s1_move;
	logic                  wr_en, rd_en;
	logic [PW-1:0]         wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] wr_data, mem_data, value_dw, value_s1;
	req_info_t             info_s1;

	assign value_dw  = DATA_WIDTH'($unsigned(value));
	assign out_adv   = !out_valid_q || !res_stall;
	assign cmd_stall = s1_valid_q && !out_adv;
	assign accept    = cmd_valid && !cmd_stall;
	assign s1_move   = s1_valid_q && out_adv;
	assign res_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_adv) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	rbdq_ctrl #(
		.DEPTH(DEPTH),
		.DW   (DATA_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (cmd),
		.value   (value_dw),
		.offset  (offset),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.info_s1 (info_s1),
		.value_s1(value_s1)
	);

	rbdq_mem #(
		.DEPTH(DEPTH),
		.DW   (DATA_WIDTH)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(mem_data)
	);

	rbdq_out #(
		.DW(DATA_WIDTH)
	) u_out (
		.clk       (clk),
		.load      (s1_move),
		.info_s1   (info_s1),
		.value_s1  (value_s1),
		.mem_data  (mem_data),
		.status    (status),
		.read_data (read_data),
		.front_data(front_data),
		.back_data (back_data),
		.count     (count),
		.is_empty  (is_empty)
	);

	`RBDQ_ASSERT_NOW(a_stall_only_when_full, cmd_stall, s1_valid_q && out_valid_q && res_stall)
	`RBDQ_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_q)
	`RBDQ_ASSERT_NEXT(a_move_fills_out, s1_move, out_valid_q)
	`RBDQ_ASSERT_NOW(a_underflow_empty, out_valid_q && status == ST_UNDERFLOW, is_empty)

endmodule
